FILE: hw/rtl/trie_prefix_counter_assert.svh
// ---------------------------------------------------------------------------
// trie_prefix_counter_assert.svh
// Assertion macros for the trie prefix counter; empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef TRIE_PREFIX_COUNTER_ASSERT_SVH
`define TRIE_PREFIX_COUNTER_ASSERT_SVH

`ifndef SYNTHESIS

// cond holds at every edge out of reset
`define TPC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tpc assertion failed");

// ant at one edge implies cons at the next
`define TPC_ASSERT_NEXT(lbl, clk, rst_n, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("tpc assertion failed");

`else

`define TPC_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define TPC_ASSERT_NEXT(lbl, clk, rst_n, ant, cons)

`endif

`endif

FILE: hw/rtl/tpc_pkg.sv
// ---------------------------------------------------------------------------
// tpc_pkg
// Shared types, codes and the character mapping of the trie prefix counter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpc_pkg;

    localparam int unsigned NODES_DEF       = 4096;
    localparam int unsigned ALPHABET_DEF    = 62;
    localparam int unsigned COUNT_WIDTH_DEF = 16;

    localparam int unsigned CMD_W       = 2;
    localparam int unsigned SYM_W       = 8;
    localparam int unsigned CODE_W      = 6;
    localparam int unsigned OUT_W       = 16;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 24;

    localparam logic [SYM_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [SYM_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [SYM_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [SYM_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [SYM_W-1:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [SYM_W-1:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [CODE_W-1:0] LOWER_BASE  = 6'd26;
    localparam logic [CODE_W-1:0] DIGIT_BASE  = 6'd52;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BADCHAR = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_LOOK,
        S_CNT,
        S_ZERO,
        S_DONE
    } t_state;

    typedef struct packed {
        logic rd;
        logic wr;
        logic wipe;
    } t_mem_ctl;

    typedef struct packed {
        logic              ok;
        logic [CODE_W-1:0] code;
    } t_code;

    function automatic t_code sym_code(input logic [SYM_W-1:0] s);
        t_code r;
        r.ok   = 1'b1;
        r.code = '0;
        if (s inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
            r.code = CODE_W'(s - CHAR_UPPER_A);
        end else if (s inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
            r.code = CODE_W'(s - CHAR_LOWER_A) + LOWER_BASE;
        end else if (s inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]}) begin
            r.code = CODE_W'(s - CHAR_DIGIT_0) + DIGIT_BASE;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tpc_child_mem.sv
// ---------------------------------------------------------------------------
// tpc_child_mem
// Child table: one row per node, one lane per character code, lane writes
// and whole-row wipe, registered row read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_child_mem
    import tpc_pkg::*;
#(
    parameter int unsigned NODES    = NODES_DEF,
    parameter int unsigned ALPHABET = ALPHABET_DEF,
    localparam int unsigned IDX_W   = $clog2(NODES)
) (
    input  wire logic                              i_clk,
    input  wire t_mem_ctl                          i_ctl,
    input  wire logic [IDX_W-1:0]                  i_addr,
    input  wire logic [CODE_W-1:0]                 i_lane,
    input  wire logic [IDX_W-1:0]                  i_data,
    output logic      [ALPHABET-1:0][IDX_W-1:0]    o_row
);

    logic [ALPHABET-1:0][IDX_W-1:0] r_mem [NODES];
    logic [ALPHABET-1:0][IDX_W-1:0] r_row;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            if (i_ctl.wipe) begin
                r_mem[i_addr] <= '0;
            end else begin
                r_mem[i_addr][i_lane] <= i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_row <= r_mem[i_addr];
        end
    end

    assign o_row = r_row;

endmodule

`default_nettype wire

FILE: hw/rtl/tpc_count_mem.sv
// ---------------------------------------------------------------------------
// tpc_count_mem
// Prefix count store: one count per node, single port, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpc_count_mem
    import tpc_pkg::*;
#(
    parameter int unsigned NODES       = NODES_DEF,
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF,
    localparam int unsigned IDX_W      = $clog2(NODES)
) (
    input  wire logic                   i_clk,
    input  wire t_mem_ctl               i_ctl,
    input  wire logic [IDX_W-1:0]       i_addr,
    input  wire logic [COUNT_WIDTH-1:0] i_data,
    output logic      [COUNT_WIDTH-1:0] o_q
);

    logic [COUNT_WIDTH-1:0] r_mem [NODES];
    logic [COUNT_WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_addr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tpc_walk_ctrl.sv
// ---------------------------------------------------------------------------
// tpc_walk_ctrl
// Walk sequencer: reads the cursor's child row, allocates or follows the
// child, updates its count and builds the end-of-string result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "trie_prefix_counter_assert.svh"

module tpc_walk_ctrl
    import tpc_pkg::*;
#(
    parameter int unsigned NODES       = NODES_DEF,
    parameter int unsigned ALPHABET    = ALPHABET_DEF,
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF,
    localparam int unsigned IDX_W      = $clog2(NODES)
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [CMD_W-1:0]               i_cmd,
    input  wire logic [SYM_W-1:0]               i_symbol,
    input  wire logic                           i_last,
    output t_mem_ctl                            o_child_ctl,
    output logic      [IDX_W-1:0]               o_child_addr,
    output logic      [CODE_W-1:0]              o_child_lane,
    output logic      [IDX_W-1:0]               o_child_data,
    input  wire logic [ALPHABET-1:0][IDX_W-1:0] i_child_row,
    output t_mem_ctl                            o_cnt_ctl,
    output logic      [IDX_W-1:0]               o_cnt_addr,
    output logic      [COUNT_WIDTH-1:0]         o_cnt_data,
    input  wire logic [COUNT_WIDTH-1:0]         i_cnt_q,
    output logic                                o_res_valid,
    input  wire logic                           i_res_ready,
    output logic      [OUT_W-1:0]               o_res_count,
    output logic      [STATUS_W-1:0]            o_res_status
);

    localparam logic [IDX_W:0] NODES_EXT = (IDX_W+1)'(NODES);
    localparam logic [32:0]    OUT_MAX   = 33'((1 << OUT_W) - 1);

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_cursor, n_cursor;
    logic [IDX_W-1:0]    r_next_free, n_next_free;
    logic                r_miss, n_miss;
    t_status             r_err, n_err;
    t_cmd                r_cmd, n_cmd;
    logic [CODE_W-1:0]   r_code, n_code;
    logic                r_last, n_last;
    logic [OUT_W-1:0]    r_res, n_res;

    t_cmd                w_cmd;
    t_code               w_code;
    logic                w_accept;
    logic                w_skip;
    logic                w_walk;
    logic [IDX_W-1:0]    w_child;
    logic                w_has_child;
    logic [IDX_W:0]      w_nf_inc;
    logic                w_full;
    logic [COUNT_WIDTH-1:0] w_cnt_inc;
    logic [32:0]         w_cnt_ext;
    logic [OUT_W-1:0]    w_cnt_clip;

    assign w_cmd       = t_cmd'(i_cmd);
    assign w_code      = sym_code(i_symbol);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_skip      = (r_err != ST_OK) || r_miss;
    assign w_walk      = ((w_cmd == CMD_INSERT) || (w_cmd == CMD_QUERY)) && !w_skip
                         && w_code.ok;
    assign w_child     = i_child_row[r_code];
    assign w_has_child = (w_child != '0);
    assign w_nf_inc    = {1'b0, r_next_free} + 1'b1;
    assign w_full      = (w_nf_inc >= NODES_EXT);
    assign w_cnt_inc   = (&i_cnt_q) ? i_cnt_q : i_cnt_q + 1'b1;
    assign w_cnt_ext   = 33'(i_cnt_q);
    assign w_cnt_clip  = (w_cnt_ext > OUT_MAX) ? '1 : w_cnt_ext[OUT_W-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: n_state = S_IDLE;
            S_IDLE: begin
                if (w_accept) begin
                    case (w_cmd)
                        CMD_CLEAR: n_state = S_INIT;
                        CMD_INSERT, CMD_QUERY: begin
                            if (w_walk) begin
                                n_state = S_LOOK;
                            end else if (i_last) begin
                                n_state = S_DONE;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LOOK: begin
                if (r_cmd == CMD_QUERY) begin
                    if (w_has_child && r_last) begin
                        n_state = S_CNT;
                    end else begin
                        n_state = r_last ? S_DONE : S_IDLE;
                    end
                end else if (w_has_child) begin
                    n_state = S_CNT;
                end else if (w_full) begin
                    n_state = r_last ? S_DONE : S_IDLE;
                end else begin
                    n_state = S_ZERO;
                end
            end
            S_CNT:  n_state = r_last ? S_DONE : S_IDLE;
            S_ZERO: n_state = r_last ? S_DONE : S_IDLE;
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    // memory controls and handshakes
    always_comb begin
        o_in_ready   = 1'b0;
        o_res_valid  = 1'b0;
        o_child_ctl  = '0;
        o_child_addr = r_cursor;
        o_child_lane = r_code;
        o_child_data = w_nf_inc[IDX_W-1:0];
        o_cnt_ctl    = '0;
        o_cnt_addr   = w_child;
        o_cnt_data   = w_cnt_inc;
        case (r_state)
            S_INIT: begin
                o_child_ctl.wr   = 1'b1;
                o_child_ctl.wipe = 1'b1;
                o_child_addr     = '0;
            end
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_child_ctl.rd = i_in_valid && w_walk;
            end
            S_LOOK: begin
                if (w_has_child) begin
                    o_cnt_ctl.rd = (r_cmd == CMD_INSERT) || r_last;
                end else if (r_cmd == CMD_INSERT && !w_full) begin
                    // hook the new node under the cursor and start its count at one
                    o_child_ctl.wr = 1'b1;
                    o_cnt_ctl.wr   = 1'b1;
                    o_cnt_addr     = w_nf_inc[IDX_W-1:0];
                    o_cnt_data     = COUNT_WIDTH'(1);
                end
            end
            S_CNT: begin
                o_cnt_ctl.wr = (r_cmd == CMD_INSERT);
                o_cnt_addr   = r_cursor;
            end
            S_ZERO: begin
                o_child_ctl.wr   = 1'b1;
                o_child_ctl.wipe = 1'b1;
            end
            S_DONE: o_res_valid = 1'b1;
            default: o_in_ready = 1'b0;
        endcase
    end

    // walk registers
    always_comb begin
        n_cursor    = r_cursor;
        n_next_free = r_next_free;
        n_miss      = r_miss;
        n_err       = r_err;
        n_cmd       = r_cmd;
        n_code      = r_code;
        n_last      = r_last;
        n_res       = r_res;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd  = w_cmd;
                    n_code = w_code.code;
                    n_last = i_last;
                    n_res  = '0;
                    if (w_cmd == CMD_CLEAR) begin
                        n_next_free = '0;
                        n_cursor    = '0;
                        n_miss      = 1'b0;
                        n_err       = ST_OK;
                    end else if ((w_cmd == CMD_INSERT || w_cmd == CMD_QUERY) && !w_skip
                                 && !w_code.ok) begin
                        n_err = ST_BADCHAR;
                    end
                end
            end
            S_LOOK: begin
                if (w_has_child) begin
                    n_cursor = w_child;
                end else if (r_cmd == CMD_QUERY) begin
                    n_miss = 1'b1;
                end else if (w_full) begin
                    n_err = ST_FULL;
                end else begin
                    n_next_free = w_nf_inc[IDX_W-1:0];
                    n_cursor    = w_nf_inc[IDX_W-1:0];
                end
            end
            S_CNT: begin
                if (r_cmd == CMD_QUERY) begin
                    n_res = w_cnt_clip;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_cursor = '0;
                    n_miss   = 1'b0;
                    n_err    = ST_OK;
                end
            end
            default: n_res = r_res;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cursor    <= '0;
            r_next_free <= '0;
            r_miss      <= 1'b0;
            r_err       <= ST_OK;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_next_free <= n_next_free;
            r_miss      <= n_miss;
            r_err       <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_code <= n_code;
        r_last <= n_last;
        r_res  <= n_res;
    end

    assign o_res_count  = r_res;
    assign o_res_status = r_err;

    `TPC_ASSERT_ALWAYS(a_pool_bound, i_clk, i_rst_n, ({1'b0, r_next_free} < NODES_EXT))
    `TPC_ASSERT_ALWAYS(a_cursor_alloc, i_clk, i_rst_n, (r_cursor <= r_next_free))
    `TPC_ASSERT_ALWAYS(a_no_wr_on_accept, i_clk, i_rst_n, !(o_in_ready && (o_child_ctl.wr || o_cnt_ctl.wr)))
    `TPC_ASSERT_NEXT(a_alloc_step, i_clk, i_rst_n, (o_child_ctl.wr && !o_child_ctl.wipe), (r_next_free == IDX_W'($past(r_next_free) + 1'b1)))

endmodule

`default_nettype wire

FILE: hw/rtl/trie_prefix_counter.sv
// ---------------------------------------------------------------------------
// trie_prefix_counter
// Character trie with per-node prefix counts, one character per beat.
// ---------------------------------------------------------------------------
// Each beat carries one character with a command (insert, query, clear) and
// tlast on the final character of a string; one result beat leaves per
// string. The work per character is set by the single-port child table and
// count store, each with a registered read: a character that is skipped
// (invalid, or after a miss or error) is only accepted; a query step reads
// the row; an insert step reads the row, then does a count read-modify-write
// or a row write plus wipe of the freshly allocated row (neither when the
// pool is already full); the last character then hands over the result,
// after a count read for a query that reports one. A clear rewipes the root
// row, as the block does after reset before it takes a beat. A new beat is
// taken while the previous result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module trie_prefix_counter
    import tpc_pkg::*;
#(
    parameter int unsigned NODES       = NODES_DEF,
    parameter int unsigned ALPHABET    = ALPHABET_DEF,
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // cmd[1:0], symbol[9:2]
    input  wire logic                   i_s_axis_tlast,   // last_char
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic      [OUT_TDATA_W-1:0] o_m_axis_tdata    // prefix_count[15:0], status[17:16]
);

    localparam int unsigned IDX_W = $clog2(NODES);

    t_mem_ctl                       w_child_ctl;
    logic [IDX_W-1:0]               w_child_addr;
    logic [CODE_W-1:0]              w_child_lane;
    logic [IDX_W-1:0]               w_child_data;
    logic [ALPHABET-1:0][IDX_W-1:0] w_child_row;
    t_mem_ctl                       w_cnt_ctl;
    logic [IDX_W-1:0]               w_cnt_addr;
    logic [COUNT_WIDTH-1:0]         w_cnt_data;
    logic [COUNT_WIDTH-1:0]         w_cnt_q;
    logic                           w_res_valid;
    logic                           w_res_ready;
    logic [OUT_W-1:0]               w_res_count;
    logic [STATUS_W-1:0]            w_res_status;

    logic                           r_m_valid;
    logic [OUT_TDATA_W-1:0]         r_m_data;

    tpc_walk_ctrl #(
        .NODES       (NODES),
        .ALPHABET    (ALPHABET),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_cmd        (i_s_axis_tdata[CMD_W-1:0]),
        .i_symbol     (i_s_axis_tdata[CMD_W+SYM_W-1:CMD_W]),
        .i_last       (i_s_axis_tlast),
        .o_child_ctl  (w_child_ctl),
        .o_child_addr (w_child_addr),
        .o_child_lane (w_child_lane),
        .o_child_data (w_child_data),
        .i_child_row  (w_child_row),
        .o_cnt_ctl    (w_cnt_ctl),
        .o_cnt_addr   (w_cnt_addr),
        .o_cnt_data   (w_cnt_data),
        .i_cnt_q      (w_cnt_q),
        .o_res_valid  (w_res_valid),
        .i_res_ready  (w_res_ready),
        .o_res_count  (w_res_count),
        .o_res_status (w_res_status)
    );

    tpc_child_mem #(
        .NODES    (NODES),
        .ALPHABET (ALPHABET)
    ) u_child_mem (
        .i_clk  (i_clk),
        .i_ctl  (w_child_ctl),
        .i_addr (w_child_addr),
        .i_lane (w_child_lane),
        .i_data (w_child_data),
        .o_row  (w_child_row)
    );

    tpc_count_mem #(
        .NODES       (NODES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_count_mem (
        .i_clk  (i_clk),
        .i_ctl  (w_cnt_ctl),
        .i_addr (w_cnt_addr),
        .i_data (w_cnt_data),
        .o_q    (w_cnt_q)
    );

    // output register: take a new result once the held beat has gone
    assign w_res_ready = !r_m_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_m_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_m_data <= {(OUT_TDATA_W-OUT_W-STATUS_W)'(0), w_res_status, w_res_count};
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule

`default_nettype wire
